// File: src/ipv4hv_pkg.sv
// ipv4hv_pkg: shared types and constants of the ipv4 header validator
// holds the drop reason codes, header constants and the result record
// no dependencies
package ipv4hv_pkg;

    typedef enum logic [3:0] {
        REASON_OK        = 4'd0,
        REASON_TRUNCATED = 4'd1,
        REASON_IHL       = 4'd2,
        REASON_TOTAL_HDR = 4'd3,
        REASON_SHORT     = 4'd4,
        REASON_VERSION   = 4'd5,
        REASON_CHECKSUM  = 4'd6,
        REASON_UNICAST   = 4'd7,
        REASON_NOT_OURS  = 4'd8,
        REASON_FRAGMENT  = 4'd9
    } t_reason;

    typedef enum logic [1:0] {
        CFG_LOCAL_ADDRESS = 2'd0,
        CFG_SUBNET_MASK   = 2'd1,
        CFG_LOOPBACK_MODE = 2'd2
    } t_cfg_index;

    localparam logic [3:0]  MIN_HEADER_WORDS = 4'd5;
    localparam logic [3:0]  IP_VERSION       = 4'd4;
    localparam logic [15:0] DF_BIT           = 16'h4000;
    localparam logic [15:0] SUM_GOOD         = 16'hFFFF;
    localparam logic [31:0] LIMITED_BCAST    = 32'hFFFF_FFFF;
    localparam logic [3:0]  MCAST_PREFIX     = 4'hE;

    typedef struct packed {
        logic        accepted;
        t_reason     drop_reason;
        logic [7:0]  protocol_number;
        logic [5:0]  header_bytes;
        logic [15:0] datagram_length;
        logic        broadcast_l3;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } t_result;

endpackage

// File: src/ipv4_header_validator.sv
// ipv4_header_validator: checks an ipv4 header arriving as 32-bit words and
// emits one verdict beat per packet; uses ipv4hv_pkg for codes and the result record
//
//   channel   direction  handshake                       payload
//   in        sink       i_in_valid / o_in_stall         header word, first/last, lengths
//   out       source     o_out_valid / i_out_stall       verdict and header fields
//   cfg       sink       i_cfg_valid / o_cfg_ready       register index, write data
//
// one header word is taken per cycle while o_in_stall is low; the verdict is
// registered from the word that completes the header (or the early last word)
// a two-entry output stage (result register plus skid register) lets input
// continue while a verdict waits; input stalls only when both entries are full
// synchronous active-low reset clears control state and the configuration registers
// configuration writes are always ready and take effect in the next cycle
module ipv4_header_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_header_word,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic [15:0] i_packet_length,
    input  logic        i_unicast_forbidden,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_accepted,
    output ipv4hv_pkg::t_reason o_drop_reason,
    output logic [7:0]  o_protocol_number,
    output logic [5:0]  o_header_bytes,
    output logic [15:0] o_datagram_length,
    output logic        o_broadcast_l3,
    output logic [31:0] o_source_address,
    output logic [31:0] o_destination_address,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ipv4hv_pkg::*;

    // configuration
    logic [31:0] r_local_address;
    logic [31:0] r_subnet_mask;
    logic        r_loopback_mode;

    // per-packet state
    logic [3:0]  r_word_index,   n_word_index;
    logic [15:0] r_sum,          n_sum;
    logic [3:0]  r_header_words, n_header_words;
    logic [15:0] r_total_length, n_total_length;
    logic [15:0] r_packet_length, n_packet_length;
    logic        r_uc_forbidden, n_uc_forbidden;
    logic [3:0]  r_version,      n_version;
    logic [15:0] r_frag_field,   n_frag_field;
    logic [7:0]  r_protocol,     n_protocol;
    logic [31:0] r_source,       n_source;
    logic [31:0] r_destination,  n_destination;
    logic        r_done,         n_done;

    // output stage
    logic        r_out_valid;
    t_result     r_out;
    logic        r_skd_valid;
    t_result     r_skd;

    logic        in_acc;
    logic        out_take;
    logic        active;
    logic        res_valid;
    t_result     res;
    logic [4:0]  required;
    logic [31:0] subnet_bc;
    logic        is_bcast;
    t_reason     reason;
    logic        bcast_out;

    function automatic logic [15:0] fold16(input logic [17:0] s);
        logic [16:0] t;
        logic [16:0] u;
        t = {1'b0, s[15:0]} + {15'd0, s[17:16]};
        u = {1'b0, t[15:0]} + {16'd0, t[16]};
        return u[15:0];
    endfunction

    assign o_in_stall  = r_skd_valid;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_out_valid && !i_out_stall;
    assign active      = i_first_word || !r_done;
    assign o_cfg_ready = 1'b1;
    assign subnet_bc   = (r_local_address & r_subnet_mask) | ~r_subnet_mask;

    always_comb begin
        n_word_index    = r_word_index;
        n_sum           = r_sum;
        n_header_words  = r_header_words;
        n_total_length  = r_total_length;
        n_packet_length = r_packet_length;
        n_uc_forbidden  = r_uc_forbidden;
        n_version       = r_version;
        n_frag_field    = r_frag_field;
        n_protocol      = r_protocol;
        n_source        = r_source;
        n_destination   = r_destination;

        if (i_first_word) begin
            n_word_index    = '0;
            n_sum           = '0;
            n_header_words  = '0;
            n_total_length  = '0;
            n_packet_length = i_packet_length;
            n_uc_forbidden  = i_unicast_forbidden;
            n_version       = '0;
            n_frag_field    = '0;
            n_protocol      = '0;
            n_source        = '0;
            n_destination   = '0;
        end

        // capture the field carried by this word
        case (n_word_index)
            4'd0: begin
                n_version      = i_header_word[31:28];
                n_header_words = i_header_word[27:24];
                n_total_length = i_header_word[15:0];
            end
            4'd1: n_frag_field  = i_header_word[15:0];
            4'd2: n_protocol    = i_header_word[23:16];
            4'd3: n_source      = i_header_word;
            4'd4: n_destination = i_header_word;
            default: ;
        endcase

        n_sum = fold16({2'b00, n_sum} + {2'b00, i_header_word[31:16]}
                       + {2'b00, i_header_word[15:0]});

        required = (n_header_words < MIN_HEADER_WORDS) ? {1'b0, MIN_HEADER_WORDS}
                                                       : {1'b0, n_header_words};

        // destination class
        is_bcast = (n_destination == LIMITED_BCAST) || (n_destination == subnet_bc)
                   || (n_destination[31:28] == MCAST_PREFIX);

        // checks in priority order
        bcast_out = 1'b0;
        if (n_header_words < MIN_HEADER_WORDS) begin
            reason = REASON_IHL;
        end else if (n_total_length < {10'd0, n_header_words, 2'b00}) begin
            reason = REASON_TOTAL_HDR;
        end else if (n_packet_length < n_total_length) begin
            reason = REASON_SHORT;
        end else if (n_version != IP_VERSION) begin
            reason = REASON_VERSION;
        end else if (n_sum != SUM_GOOD) begin
            reason = REASON_CHECKSUM;
        end else if (!r_loopback_mode && n_uc_forbidden && !is_bcast) begin
            reason = REASON_UNICAST;
        end else if (!r_loopback_mode && !is_bcast && n_destination != r_local_address) begin
            reason = REASON_NOT_OURS;
        end else if ((n_frag_field & ~DF_BIT) != 16'd0) begin
            reason = REASON_FRAGMENT;
            bcast_out = !r_loopback_mode && is_bcast;
        end else begin
            reason = REASON_OK;
            bcast_out = !r_loopback_mode && is_bcast;
        end

        res_valid = 1'b0;
        n_done    = 1'b0;
        if (({1'b0, n_word_index} + 5'd1) >= required) begin
            res_valid = active;
            n_done    = 1'b1;
        end else if (i_last_word) begin
            // header cut short by end of packet
            reason    = REASON_TRUNCATED;
            bcast_out = 1'b0;
            res_valid = active;
            n_done    = 1'b1;
        end
        res_valid = res_valid && in_acc;

        n_word_index = n_word_index + 4'd1;

        res.accepted            = (reason == REASON_OK);
        res.drop_reason         = reason;
        res.protocol_number     = n_protocol;
        res.header_bytes        = {n_header_words, 2'b00};
        res.datagram_length     = n_total_length;
        res.broadcast_l3        = bcast_out;
        res.source_address      = n_source;
        res.destination_address = n_destination;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done          <= 1'b1;
            r_out_valid     <= 1'b0;
            r_skd_valid     <= 1'b0;
            r_local_address <= '0;
            r_subnet_mask   <= '0;
            r_loopback_mode <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LOCAL_ADDRESS: r_local_address <= i_cfg_data;
                    CFG_SUBNET_MASK:   r_subnet_mask   <= i_cfg_data;
                    CFG_LOOPBACK_MODE: r_loopback_mode <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (in_acc && active) begin
                r_word_index    <= n_word_index;
                r_sum           <= n_sum;
                r_header_words  <= n_header_words;
                r_total_length  <= n_total_length;
                r_packet_length <= n_packet_length;
                r_uc_forbidden  <= n_uc_forbidden;
                r_version       <= n_version;
                r_frag_field    <= n_frag_field;
                r_protocol      <= n_protocol;
                r_source        <= n_source;
                r_destination   <= n_destination;
                r_done          <= n_done;
            end

            // output register refills from skid first, skid catches a stalled beat
            if (!r_out_valid || out_take) begin
                if (r_skd_valid) begin
                    r_out       <= r_skd;
                    r_out_valid <= 1'b1;
                    r_skd_valid <= 1'b0;
                end else begin
                    r_out       <= res;
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skd       <= res;
                r_skd_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_accepted            = r_out.accepted;
    assign o_drop_reason         = r_out.drop_reason;
    assign o_protocol_number     = r_out.protocol_number;
    assign o_header_bytes        = r_out.header_bytes;
    assign o_datagram_length     = r_out.datagram_length;
    assign o_broadcast_l3        = r_out.broadcast_l3;
    assign o_source_address      = r_out.source_address;
    assign o_destination_address = r_out.destination_address;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register full while output register empty");

    a_bcast_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_broadcast_l3) |->
            (o_drop_reason == REASON_OK || o_drop_reason == REASON_FRAGMENT))
        else $error("broadcast flag set on a verdict that stopped before the address check");

    a_accept_min_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |->
            (o_header_bytes >= 6'd20 && o_datagram_length >= {10'd0, o_header_bytes}))
        else $error("accepted verdict with an invalid header length");

    a_no_lost_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_skd_valid) |=> (r_skd_valid && r_out_valid))
        else $error("buffered verdict dropped while output was stalled");
`endif

endmodule
